[hdl/polynomial_accumulator_add_mul_assert.svh]
// Assertion macros for the polynomial accumulator.
`ifndef POLYNOMIAL_ACCUMULATOR_ADD_MUL_ASSERT_SVH
`define POLYNOMIAL_ACCUMULATOR_ADD_MUL_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PAM_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PAM_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/pam_pkg.sv]
// Shared constants and types for the polynomial accumulator.
`default_nettype none

package pam_pkg;

  localparam int unsigned COEF_WIDTH_DEF = 32;
  localparam int unsigned IO_WIDTH       = 32;
  localparam int unsigned NUM_TERMS      = 11;
  localparam int unsigned DEG_WIDTH      = 5;
  localparam int unsigned STEP_WIDTH     = $clog2(NUM_TERMS);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_MUL = 1'b1;

  typedef struct packed {
    logic load;
    logic add;
    logic mul;
    logic first;
    logic last;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/pam_cell.sv]
// One coefficient cell: accumulator term, operand term and partial product.
`default_nettype none

module pam_cell #(
  parameter int unsigned COEF_WIDTH = pam_pkg::COEF_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pam_pkg::cell_ctrl_t     ctrl,
  input  logic [COEF_WIDTH-1:0]   operand,
  input  logic [COEF_WIDTH-1:0]   bcast,
  input  logic [COEF_WIDTH-1:0]   acc_in,
  input  logic [COEF_WIDTH-1:0]   psum_in,
  output logic [COEF_WIDTH-1:0]   acc,
  output logic [COEF_WIDTH-1:0]   psum,
  output logic                    nonzero
);

  import pam_pkg::*;

  logic [COEF_WIDTH-1:0] operand_q;
  logic [COEF_WIDTH-1:0] prod;
  logic [COEF_WIDTH-1:0] sum;

  assign prod    = bcast * operand_q;
  assign sum     = (ctrl.first ? '0 : psum_in) + prod;
  assign nonzero = |acc;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      operand_q <= operand;
    end
    if (ctrl.mul) begin
      psum <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + operand_q;
    end else if (ctrl.mul) begin
      acc <= ctrl.last ? sum : acc_in;
    end
  end

endmodule

`default_nettype wire

[hdl/polynomial_accumulator_add_mul.sv]
// Polynomial accumulator top level: request handshake, sequencing, cell chain, result register.
//
// Input channel (in_valid/in_ready): opcode plus operand coefficients coef_0..coef_10.
// Opcode add sums the operand into the accumulator; opcode multiply replaces the
// accumulator with the product, truncated at degree 10. Coefficients wrap.
// Output channel (out_valid/out_ready): new accumulator acc_0..acc_10 and its degree,
// -1 for the zero polynomial. Every request gives exactly one result.
// Multiply runs as a Horner sweep over a chain of 11 cells, one accumulator term per
// cycle broadcast from the top cell while partial sums move up one cell a cycle;
// the next request is taken only after that 11-step sweep; add takes one step in the cells.
// A result register parts the two channels: the next request is taken while a
// finished result waits; loading a new result waits for out_ready, and so does a request taken with that load.
// Reset clears the accumulator to zero and empties the result register.
`default_nettype none

module polynomial_accumulator_add_mul #(
  parameter int unsigned COEF_WIDTH = pam_pkg::COEF_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_0,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_1,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_2,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_3,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_4,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_5,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_6,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_7,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_8,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_9,
  input  logic signed [pam_pkg::IO_WIDTH-1:0] coef_10,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_0,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_1,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_2,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_3,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_4,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_5,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_6,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_7,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_8,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_9,
  output logic signed [pam_pkg::IO_WIDTH-1:0] acc_10,
  output logic signed [pam_pkg::DEG_WIDTH-1:0] degree
);

  import pam_pkg::*;

  `include "polynomial_accumulator_add_mul_assert.svh"

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUM_TERMS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [STEP_WIDTH-1:0]   step;
  logic [STEP_WIDTH-1:0]   step_next;
  logic                    op_mul;
  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  cell_ctrl_t              ctrl;

  logic signed [IO_WIDTH-1:0] coef_arr [NUM_TERMS];
  logic [COEF_WIDTH-1:0]      operand_w [NUM_TERMS];
  logic [COEF_WIDTH-1:0]      acc_w [NUM_TERMS];
  logic [COEF_WIDTH-1:0]      psum_w [NUM_TERMS];
  logic [NUM_TERMS-1:0]       nz_w;
  logic [DEG_WIDTH-1:0]       deg_w;

  logic [COEF_WIDTH-1:0]      out_acc [NUM_TERMS];
  logic [DEG_WIDTH-1:0]       out_degree;

  assign coef_arr[0]  = coef_0;
  assign coef_arr[1]  = coef_1;
  assign coef_arr[2]  = coef_2;
  assign coef_arr[3]  = coef_3;
  assign coef_arr[4]  = coef_4;
  assign coef_arr[5]  = coef_5;
  assign coef_arr[6]  = coef_6;
  assign coef_arr[7]  = coef_7;
  assign coef_arr[8]  = coef_8;
  assign coef_arr[9]  = coef_9;
  assign coef_arr[10] = coef_10;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_DONE) && out_free;

  assign ctrl.load  = accept;
  assign ctrl.add   = (state == S_RUN) && !op_mul;
  assign ctrl.mul   = (state == S_RUN) && op_mul;
  assign ctrl.first = (step == '0);
  assign ctrl.last  = (step == LAST_STEP);

  genvar k;
  generate
    for (k = 0; k < NUM_TERMS; k++) begin : g_cell
      assign operand_w[k] = COEF_WIDTH'(coef_arr[k]);
      pam_cell #(
        .COEF_WIDTH(COEF_WIDTH)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .operand (operand_w[k]),
        .bcast   (acc_w[NUM_TERMS-1]),
        .acc_in  ((k == 0) ? '0 : acc_w[(k == 0) ? 0 : k-1]),
        .psum_in ((k == 0) ? '0 : psum_w[(k == 0) ? 0 : k-1]),
        .acc     (acc_w[k]),
        .psum    (psum_w[k]),
        .nonzero (nz_w[k])
      );
    end
  endgenerate

  always_comb begin
    deg_w = '1;
    for (int i = 0; i < NUM_TERMS; i++) begin
      if (nz_w[i]) begin
        deg_w = DEG_WIDTH'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
          step_next  = '0;
        end
      end
      S_RUN: begin
        if (!op_mul || (step == LAST_STEP)) begin
          state_next = S_DONE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DONE: begin
        if (accept) begin
          state_next = S_RUN;
          step_next  = '0;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mul <= (opcode == OP_MUL);
    end
    if (out_load) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        out_acc[i] <= acc_w[i];
      end
      out_degree <= deg_w;
    end
  end

  assign acc_0  = IO_WIDTH'(out_acc[0]);
  assign acc_1  = IO_WIDTH'(out_acc[1]);
  assign acc_2  = IO_WIDTH'(out_acc[2]);
  assign acc_3  = IO_WIDTH'(out_acc[3]);
  assign acc_4  = IO_WIDTH'(out_acc[4]);
  assign acc_5  = IO_WIDTH'(out_acc[5]);
  assign acc_6  = IO_WIDTH'(out_acc[6]);
  assign acc_7  = IO_WIDTH'(out_acc[7]);
  assign acc_8  = IO_WIDTH'(out_acc[8]);
  assign acc_9  = IO_WIDTH'(out_acc[9]);
  assign acc_10 = IO_WIDTH'(out_acc[10]);
  assign degree = out_degree;

  `PAM_CHECK(a_step_range, step <= LAST_STEP, "step counter past last term")
  `PAM_CHECK(a_add_one_step, (state == S_RUN && !op_mul) |=> (state == S_DONE), "add took more than one step")
  `PAM_CHECK(a_mul_sweep, (state == S_RUN && op_mul && step != LAST_STEP) |=> (state == S_RUN), "multiply sweep cut short")
  `PAM_CHECK(a_result_loaded, (state == S_DONE && out_free) |=> out_valid, "finished request not presented")
  `PAM_CHECK_ALWAYS(a_reset_empty, rst |=> !out_valid, "result pending after reset")

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Testbench for the polynomial accumulator: a directed table of requests, then random add and multiply requests, all checked.
`default_nettype none

module tb_top;
  import pam_pkg::*;

  typedef logic [NUM_TERMS-1:0][IO_WIDTH-1:0] poly_t;
  typedef struct packed {
    logic  op;
    poly_t coef;
  } poly_req_t;
  typedef struct packed {
    poly_t                acc;
    logic [DEG_WIDTH-1:0] deg;
  } poly_res_t;

  localparam logic [DEG_WIDTH-1:0] DEG_ZERO = '1;
  localparam int NUM_RANDOM  = 1930;
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_LIMIT = 40;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [IO_WIDTH-1:0] acc_0, acc_1, acc_2, acc_3, acc_4, acc_5;
  logic signed [IO_WIDTH-1:0] acc_6, acc_7, acc_8, acc_9, acc_10;
  logic signed [DEG_WIDTH-1:0] degree;

  poly_req_t cur_req;
  logic      cur_typed;
  poly_res_t cur_typed_res;

  poly_t     acc_state;
  poly_res_t acc_due[$];
  poly_req_t dir_req[$];
  poly_res_t dir_res[$];
  logic      dir_typed[$];

  int errors    = 0;
  int printed   = 0;
  int n_add     = 0;
  int n_mul     = 0;
  int n_res     = 0;
  int n_zero    = 0;
  int n_stalled = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  polynomial_accumulator_add_mul dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (cur_req.op),
    .coef_0   (cur_req.coef[0]),
    .coef_1   (cur_req.coef[1]),
    .coef_2   (cur_req.coef[2]),
    .coef_3   (cur_req.coef[3]),
    .coef_4   (cur_req.coef[4]),
    .coef_5   (cur_req.coef[5]),
    .coef_6   (cur_req.coef[6]),
    .coef_7   (cur_req.coef[7]),
    .coef_8   (cur_req.coef[8]),
    .coef_9   (cur_req.coef[9]),
    .coef_10  (cur_req.coef[10]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .acc_0    (acc_0),
    .acc_1    (acc_1),
    .acc_2    (acc_2),
    .acc_3    (acc_3),
    .acc_4    (acc_4),
    .acc_5    (acc_5),
    .acc_6    (acc_6),
    .acc_7    (acc_7),
    .acc_8    (acc_8),
    .acc_9    (acc_9),
    .acc_10   (acc_10),
    .degree   (degree)
  );

  function automatic poly_res_t apply_request(poly_req_t r);
    poly_t     nxt;
    poly_res_t res;
    nxt = '0;
    if (r.op == OP_MUL) begin
      for (int i = 0; i < NUM_TERMS; i++)
        for (int j = 0; i + j < NUM_TERMS; j++)
          nxt[i+j] = nxt[i+j] + acc_state[i] * r.coef[j];
    end else begin
      for (int i = 0; i < NUM_TERMS; i++)
        nxt[i] = acc_state[i] + r.coef[i];
    end
    acc_state = nxt;
    res.acc = nxt;
    res.deg = DEG_ZERO;
    for (int i = 0; i < NUM_TERMS; i++)
      if (nxt[i] != '0) res.deg = DEG_WIDTH'(i);
    return res;
  endfunction

  function automatic poly_t mono(int k, logic [IO_WIDTH-1:0] v);
    poly_t p;
    p = '0;
    p[k] = v;
    return p;
  endfunction

  function automatic logic [IO_WIDTH-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'($urandom_range(0, 15));
      6: return -32'($urandom_range(1, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic int draw_gap(int idx);
    if (idx % 500 < 100) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic report_mismatch(string field, logic [IO_WIDTH-1:0] got,
                                 logic [IO_WIDTH-1:0] want);
    errors++;
    if (printed < PRINT_LIMIT) begin
      printed++;
      $display("tb_top: result %0d %s got %h want %h", n_res, field, got, want);
    end
  endtask

  task automatic add_row(logic op, poly_t coef, logic typed, poly_t acc,
                         logic [DEG_WIDTH-1:0] deg);
    poly_req_t r;
    poly_res_t res;
    r.op = op;
    r.coef = coef;
    res.acc = acc;
    res.deg = deg;
    dir_req.push_back(r);
    dir_res.push_back(res);
    dir_typed.push_back(typed);
  endtask

  task automatic send(poly_req_t r, logic typed, poly_res_t res, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_req       <= r;
    cur_typed     <= typed;
    cur_typed_res <= res;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    poly_res_t due;
    poly_t     got_acc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_acc = {acc_10, acc_9, acc_8, acc_7, acc_6, acc_5,
                   acc_4, acc_3, acc_2, acc_1, acc_0};
        n_res++;
        if (degree == DEG_ZERO) n_zero++;
        if (acc_due.size() == 0) begin
          report_mismatch("degree with no request pending", 32'(degree), '0);
        end else begin
          due = acc_due.pop_front();
          for (int k = 0; k < NUM_TERMS; k++)
            if (got_acc[k] !== due.acc[k])
              report_mismatch($sformatf("acc_%0d", k), got_acc[k], due.acc[k]);
          if (degree !== due.deg)
            report_mismatch("degree", 32'(degree), 32'(due.deg));
        end
      end
      if (in_valid && !in_ready) n_stalled++;
      if (in_valid && in_ready) begin
        due = apply_request(cur_req);
        if (cur_typed) due = cur_typed_res;
        acc_due.push_back(due);
        if (cur_req.op == OP_MUL) n_mul++;
        else n_add++;
      end
    end
  end

  initial begin : drain
    int stall;
    int taken;
    taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else if (taken % 400 < 80) stall = 0;
      else stall = $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    poly_req_t r;
    poly_res_t none;
    int        top;
    int        kind;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cur_req       = '0;
    cur_typed     = 1'b0;
    cur_typed_res = '0;
    acc_state     = '0;
    none          = '0;

    add_row(OP_ADD, '0, 1'b1, '0, DEG_ZERO);
    add_row(OP_MUL, {NUM_TERMS{32'h7FFF_FFFF}}, 1'b1, '0, DEG_ZERO);
    add_row(OP_ADD, {NUM_TERMS{32'h7FFF_FFFF}}, 1'b1, {NUM_TERMS{32'h7FFF_FFFF}}, 5'd10);
    add_row(OP_ADD, {NUM_TERMS{32'h0000_0001}}, 1'b1, {NUM_TERMS{32'h8000_0000}}, 5'd10);
    add_row(OP_ADD, {NUM_TERMS{32'h8000_0000}}, 1'b1, '0, DEG_ZERO);
    add_row(OP_ADD, mono(0, 32'd1), 1'b1, mono(0, 32'd1), 5'd0);
    add_row(OP_MUL, mono(10, 32'd1), 1'b1, mono(10, 32'd1), 5'd10);
    add_row(OP_MUL, mono(1, 32'd1), 1'b1, '0, DEG_ZERO);
    add_row(OP_ADD, mono(0, 32'hFFFF_FFFF), 1'b1, mono(0, 32'hFFFF_FFFF), 5'd0);
    add_row(OP_MUL, {NUM_TERMS{32'hFFFF_FFFF}}, 1'b1, {NUM_TERMS{32'h0000_0001}}, 5'd10);
    add_row(OP_MUL, {NUM_TERMS{32'h8000_0000}}, 1'b0, '0, '0);
    add_row(OP_MUL, {NUM_TERMS{32'hFFFF_FFFF}}, 1'b0, '0, '0);
    add_row(OP_ADD, {NUM_TERMS{32'hAAAA_AAAA}}, 1'b0, '0, '0);
    add_row(OP_ADD, {NUM_TERMS{32'h5555_5555}}, 1'b0, '0, '0);
    add_row(OP_MUL, '0, 1'b1, '0, DEG_ZERO);
    add_row(OP_ADD, mono(5, 32'h1234_5678), 1'b1, mono(5, 32'h1234_5678), 5'd5);
    add_row(OP_ADD, mono(3, 32'h7FFF_FFFF), 1'b0, '0, '0);
    add_row(OP_MUL, mono(5, 32'd2), 1'b0, '0, '0);
    add_row(OP_ADD, {NUM_TERMS{32'hDEAD_BEEF}}, 1'b0, '0, '0);
    add_row(OP_MUL, {NUM_TERMS{32'h7FFF_FFFF}}, 1'b0, '0, '0);
    add_row(OP_MUL, mono(0, 32'h8000_0000) | mono(10, 32'h7FFF_FFFF), 1'b0, '0, '0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_req[n]) send(dir_req[n], dir_typed[n], dir_res[n], draw_gap(n));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      top  = $urandom_range(0, NUM_TERMS - 1);
      kind = $urandom_range(0, 19);
      r.op = (kind >= 12) ? OP_MUL : OP_ADD;
      for (int k = 0; k < NUM_TERMS; k++)
        r.coef[k] = (k <= top) ? pick_coef() : '0;
      if (kind == 0) begin
        r.op   = OP_MUL;
        r.coef = '0;
      end else if (kind <= 3) begin
        // cancel the upper terms to pull the degree down
        for (int k = top + 1; k < NUM_TERMS; k++)
          r.coef[k] = -acc_state[k];
      end
      send(r, 1'b0, none, draw_gap(n + dir_req.size()));
    end
    in_valid <= 1'b0;

    while (acc_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("tb_top: %0d requests (%0d add, %0d multiply), %0d results, %0d zero",
             n_add + n_mul, n_add, n_mul, n_res, n_zero);
    $display("tb_top: one receiver hold-off of %0d cycles; input stalled %0d cycles",
             HOLD_CYCLES, n_stalled);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: timeout, %0d results still pending", acc_due.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
